/* hw/rtl/grmr_pkg.sv */
// Shared constants, types and register codes of the grid bilinear resampler.
`timescale 1ns / 1ps
`default_nettype none
package grmr_pkg;

   // grid store geometry
   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 64;
   localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int TOT_W       = ADDR_W + 1;
   localparam int DIM_MAX     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;

   // field widths
   localparam int DIM_W   = 7;
   localparam int DATA_W  = 32;
   localparam int PITCH_W = 31;
   localparam int FRAC_W  = 16;
   localparam int W_W     = FRAC_W + 1;
   localparam int ONE_Q16 = 65536;

   // divider: quotient holds cell index and 16 fraction bits
   localparam int QUOT_W  = $clog2(DIM_MAX) + FRAC_W;
   localparam int NUM_W   = PITCH_W + QUOT_W;
   localparam int K_W     = QUOT_W - FRAC_W;
   localparam int CNT_W   = $clog2(QUOT_W + 1);
   localparam int COORD_W = PITCH_W + $clog2(DIM_MAX) + 3;

   // blend datapath
   localparam int PROD_W = DATA_W + 1;
   localparam int ACC_W  = PROD_W + 1;
   localparam int BL_W   = ACC_W + 1;

   // configuration port
   localparam int PADDR_W   = 5;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_COLUMNS = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROWS    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ORIG_X  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ORIG_Y  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PITCH   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MARKER  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_FILL    = 3'd6;

   // reset values
   localparam logic [DIM_W-1:0]   RST_COLUMNS = 7'd64;
   localparam logic [DIM_W-1:0]   RST_ROWS    = 7'd64;
   localparam logic [PITCH_W-1:0] RST_PITCH   = 31'd65536;
   localparam logic [DATA_W-1:0]  RST_MARKER  = 32'hD8F1_0000;

   // effective configuration seen by the datapath
   typedef struct packed {
      logic [DIM_W-1:0]          columns;
      logic [DIM_W-1:0]          rows;
      logic signed [DATA_W-1:0]  origin_x;
      logic signed [DATA_W-1:0]  origin_y;
      logic [PITCH_W-1:0]        pitch;
      logic signed [DATA_W-1:0]  marker;
      logic signed [DATA_W-1:0]  fill;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [NUM_W-1:0]   num;
      logic [PITCH_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [QUOT_W-1:0]  quot;
      logic [PITCH_W-1:0] rem;
   } div_rsp_type;

endpackage
`default_nettype wire

/* hw/rtl/grid_map_bilinear_resampler_unit.sv */
// Top level: item sequencer, cell location and bilinear blend of the grid resampler.
// Load item: busy for one divider pass from accept until the next item can be taken.
// Query item: the block returns to idle with the result strobe, after these steps:
//   per axis set-up (SPAN, LAST, CLAMP), a pass of the shared one-bit-per-cycle divider,
//   then corner reads (READ) and blend (BLEND, SUM). One item in flight; no receiver stall.
// Reset: synchronous, active high; clears control and load position, not the grid store.
`timescale 1ns / 1ps
`default_nettype none
module grid_map_bilinear_resampler_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_command,
   input  wire logic signed [31:0]           req_sample_value,
   input  wire logic signed [31:0]           req_query_x,
   input  wire logic signed [31:0]           req_query_y,
   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_interpolated_value,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [grmr_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LDIV  = 4'd1;
   localparam logic [3:0] ST_SPAN  = 4'd2;
   localparam logic [3:0] ST_LAST  = 4'd3;
   localparam logic [3:0] ST_CLAMP = 4'd4;
   localparam logic [3:0] ST_QDIV  = 4'd5;
   localparam logic [3:0] ST_READ  = 4'd6;
   localparam logic [3:0] ST_BLEND = 4'd7;
   localparam logic [3:0] ST_SUM   = 4'd8;

   localparam int CW = grmr_pkg::COORD_W;
   localparam logic [grmr_pkg::W_W-1:0] ONE = grmr_pkg::W_W'(grmr_pkg::ONE_Q16);

   // signed 32-bit limits at the width of the final sum
   localparam logic signed [grmr_pkg::BL_W:0] SUM_MAX =
      {{(grmr_pkg::BL_W-30){1'b0}}, {31{1'b1}}};
   localparam logic signed [grmr_pkg::BL_W:0] SUM_MIN =
      {{(grmr_pkg::BL_W-30){1'b1}}, 31'd0};

   grmr_pkg::cfg_type     cfg;
   grmr_pkg::div_req_type div_req;
   grmr_pkg::div_rsp_type div_rsp;

   logic [3:0]                   state_ff, state_in;
   logic [grmr_pkg::ADDR_W-1:0]  pos_ff, pos_in;
   logic signed [31:0]           sample_ff, sample_in;
   logic signed [31:0]           qx_ff, qx_in, qy_ff, qy_in;
   logic                         axis_ff, axis_in;
   logic signed [CW-1:0]         first_ff, first_in, last_ff, last_in;
   logic [CW-1:0]                span_ff, span_in;
   logic [grmr_pkg::K_W-1:0]     kx_ff, kx_in, ky_ff, ky_in;
   logic [grmr_pkg::W_W-1:0]     wx_ff, wx_in, wy_ff, wy_in;
   logic [2:0]                   cnt_ff, cnt_in;
   logic signed [grmr_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [grmr_pkg::ACC_W-1:0]  acc0_ff, acc0_in, acc1_ff, acc1_in;
   logic signed [grmr_pkg::BL_W-1:0]   b0_ff, b0_in, b1_ff, b1_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]           rsp_value_ff, rsp_value_in;

   logic                         accept;
   logic [grmr_pkg::TOT_W-1:0]   total;
   logic [grmr_pkg::TOT_W-1:0]   pos_next;
   logic [grmr_pkg::ADDR_W-1:0]  pos_eff;
   logic signed [31:0]           q_sel, org_sel;
   logic [grmr_pkg::DIM_W-1:0]   n_sel, n_m2;
   logic signed [CW-1:0]         q_ext, q_clamp, q_off;
   logic [grmr_pkg::K_W-1:0]     k_raw, k_fin;
   logic [grmr_pkg::W_W-1:0]     w_fin;
   logic [grmr_pkg::DIM_W-1:0]   wr_row;
   logic [grmr_pkg::ADDR_W-1:0]  wr_addr, rd_addr, mem_addr;
   logic                         mem_we;
   logic [grmr_pkg::DATA_W-1:0]  mem_rdata;
   logic [1:0]                   corner;
   logic [grmr_pkg::K_W:0]       rd_row, rd_col;
   logic [grmr_pkg::W_W-1:0]     w_sel;
   logic signed [grmr_pkg::DATA_W+grmr_pkg::W_W:0] prod_full;
   logic signed [grmr_pkg::ACC_W+grmr_pkg::W_W:0]  bl0_full, bl1_full;
   logic signed [grmr_pkg::BL_W:0] sum;

   grmr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   grmr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   grmr_store u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (sample_ff),
      .rdata (mem_rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   // load position bookkeeping
   assign total    = grmr_pkg::TOT_W'(cfg.columns * cfg.rows);
   assign pos_eff  = ({1'b0, pos_ff} >= total) ? '0 : pos_ff;
   assign pos_next = {1'b0, pos_ff} + grmr_pkg::TOT_W'(1);

   // stored row is flipped: file row 0 goes to the top
   assign wr_row  = cfg.rows - grmr_pkg::DIM_W'(1) -
                    grmr_pkg::DIM_W'(div_rsp.quot);
   assign wr_addr = grmr_pkg::ADDR_W'(int'(wr_row) * grmr_pkg::MAX_COLUMNS +
                                      int'(div_rsp.rem));

   // per-axis operands
   assign q_sel   = axis_ff ? qy_ff : qx_ff;
   assign org_sel = axis_ff ? cfg.origin_y : cfg.origin_x;
   assign n_sel   = axis_ff ? cfg.rows : cfg.columns;
   assign n_m2    = n_sel - grmr_pkg::DIM_W'(2);

   // clamp onto the span of centres
   assign q_ext   = CW'(q_sel);
   assign q_clamp = (q_ext < first_ff) ? first_ff : ((q_ext > last_ff) ? last_ff : q_ext);
   assign q_off   = q_clamp - first_ff;

   // cell index and weight from the quotient; last centre gives full weight
   assign k_raw = div_rsp.quot[grmr_pkg::QUOT_W-1:grmr_pkg::FRAC_W];
   always_comb begin
      if (grmr_pkg::DIM_W'(k_raw) > n_m2) begin
         k_fin = grmr_pkg::K_W'(n_m2);
         w_fin = ONE;
      end else begin
         k_fin = k_raw;
         w_fin = {1'b0, div_rsp.quot[grmr_pkg::FRAC_W-1:0]};
      end
   end

   // corner reads: (j,i) (j,i+1) (j+1,i) (j+1,i+1)
   assign corner  = cnt_ff[1:0];
   assign rd_row  = {1'b0, ky_ff} + (grmr_pkg::K_W+1)'(corner[1]);
   assign rd_col  = {1'b0, kx_ff} + (grmr_pkg::K_W+1)'(corner[0]);
   assign rd_addr = grmr_pkg::ADDR_W'(int'(rd_row) * grmr_pkg::MAX_COLUMNS + int'(rd_col));

   assign mem_we   = (state_ff == ST_LDIV) && div_rsp.done;
   assign mem_addr = mem_we ? wr_addr : rd_addr;

   // truncated products
   assign w_sel     = cnt_ff[0] ? (ONE - wx_ff) : wx_ff;
   assign prod_full = $signed(mem_rdata) * $signed({1'b0, w_sel});
   assign bl0_full  = acc0_ff * $signed({1'b0, ONE - wy_ff});
   assign bl1_full  = acc1_ff * $signed({1'b0, wy_ff});
   assign sum       = b0_ff + b1_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      sample_in    = sample_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      axis_in      = axis_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      span_in      = span_ff;
      kx_in        = kx_ff;
      ky_in        = ky_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      cnt_in       = cnt_ff;
      prod_in      = grmr_pkg::PROD_W'(prod_full >>> grmr_pkg::FRAC_W);
      acc0_in      = acc0_ff;
      acc1_in      = acc1_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_command) begin
                  pos_in        = pos_eff;
                  sample_in     = (req_sample_value == cfg.marker) ? cfg.fill
                                                                   : req_sample_value;
                  div_req.start = 1'b1;
                  div_req.num   = grmr_pkg::NUM_W'(pos_eff);
                  div_req.den   = grmr_pkg::PITCH_W'(cfg.columns);
                  state_in      = ST_LDIV;
               end else begin
                  qx_in    = req_query_x;
                  qy_in    = req_query_y;
                  axis_in  = 1'b0;
                  state_in = ST_SPAN;
               end
            end
         end
         ST_LDIV: begin
            if (div_rsp.done) begin
               pos_in   = (pos_next >= total) ? '0 : grmr_pkg::ADDR_W'(pos_next);
               state_in = ST_IDLE;
            end
         end
         ST_SPAN: begin
            first_in = CW'(org_sel) + $signed(CW'(cfg.pitch >> 1));
            span_in  = CW'(n_sel - grmr_pkg::DIM_W'(1)) * CW'(cfg.pitch);
            state_in = ST_LAST;
         end
         ST_LAST: begin
            last_in  = first_ff + $signed(span_ff);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            div_req.start = 1'b1;
            div_req.num   = {q_off[grmr_pkg::NUM_W-grmr_pkg::FRAC_W-1:0],
                             {grmr_pkg::FRAC_W{1'b0}}};
            div_req.den   = cfg.pitch;
            state_in      = ST_QDIV;
         end
         ST_QDIV: begin
            if (div_rsp.done) begin
               if (!axis_ff) begin
                  kx_in    = k_fin;
                  wx_in    = w_fin;
                  axis_in  = 1'b1;
                  state_in = ST_SPAN;
               end else begin
                  ky_in    = k_fin;
                  wy_in    = w_fin;
                  cnt_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // issue at 0..3, product at 1..4, accumulate at 2..5
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff)
               3'd2: acc0_in = grmr_pkg::ACC_W'(prod_ff);
               3'd3: acc0_in = acc0_ff + grmr_pkg::ACC_W'(prod_ff);
               3'd4: acc1_in = grmr_pkg::ACC_W'(prod_ff);
               3'd5: begin
                  acc1_in  = acc1_ff + grmr_pkg::ACC_W'(prod_ff);
                  state_in = ST_BLEND;
               end
               default: ;
            endcase
         end
         ST_BLEND: begin
            b0_in    = grmr_pkg::BL_W'(bl0_full >>> grmr_pkg::FRAC_W);
            b1_in    = grmr_pkg::BL_W'(bl1_full >>> grmr_pkg::FRAC_W);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // saturate to the signed 32-bit range
            if (sum > SUM_MAX)
               rsp_value_in = 32'sh7FFF_FFFF;
            else if (sum < SUM_MIN)
               rsp_value_in = 32'sh8000_0000;
            else
               rsp_value_in = sum[31:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      span_ff      <= span_in;
      kx_ff        <= kx_in;
      ky_ff        <= ky_in;
      wx_ff        <= wx_in;
      wy_ff        <= wy_in;
      prod_ff      <= prod_in;
      acc0_ff      <= acc0_in;
      acc1_ff      <= acc1_in;
      b0_ff        <= b0_in;
      b1_ff        <= b1_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = rsp_value_ff;

   // a result only follows the final sum step
   a_rsp_after_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_SUM))
      else $error("result strobe without sum step");

   // an accepted item always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   // weights never exceed one while the corners are read
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (wx_ff <= ONE && wy_ff <= ONE))
      else $error("interpolation weight above one");

endmodule
`default_nettype wire

/* hw/rtl/grmr_csr.sv */
// Configuration registers with APB-style access and effective-value clamping.
`timescale 1ns / 1ps
`default_nettype none
module grmr_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [grmr_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                  pwdata,
   output logic      [31:0]                  prdata,
   output logic                              pready,
   output grmr_pkg::cfg_type                 cfg
);

   logic [grmr_pkg::DIM_W-1:0]   columns_ff;
   logic [grmr_pkg::DIM_W-1:0]   rows_ff;
   logic [31:0]                  orig_x_ff;
   logic [31:0]                  orig_y_ff;
   logic [grmr_pkg::PITCH_W-1:0] pitch_ff;
   logic [31:0]                  marker_ff;
   logic [31:0]                  fill_ff;
   logic                         wr_en;
   logic [grmr_pkg::REG_IDX_W-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[grmr_pkg::PADDR_W-1:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= grmr_pkg::RST_COLUMNS;
         rows_ff    <= grmr_pkg::RST_ROWS;
         orig_x_ff  <= '0;
         orig_y_ff  <= '0;
         pitch_ff   <= grmr_pkg::RST_PITCH;
         marker_ff  <= grmr_pkg::RST_MARKER;
         fill_ff    <= '0;
      end else if (wr_en) begin
         case (idx)
            grmr_pkg::REG_COLUMNS: columns_ff <= pwdata[grmr_pkg::DIM_W-1:0];
            grmr_pkg::REG_ROWS:    rows_ff    <= pwdata[grmr_pkg::DIM_W-1:0];
            grmr_pkg::REG_ORIG_X:  orig_x_ff  <= pwdata;
            grmr_pkg::REG_ORIG_Y:  orig_y_ff  <= pwdata;
            grmr_pkg::REG_PITCH:   pitch_ff   <= pwdata[grmr_pkg::PITCH_W-1:0];
            grmr_pkg::REG_MARKER:  marker_ff  <= pwdata;
            grmr_pkg::REG_FILL:    fill_ff    <= pwdata;
            default: ;
         endcase
      end
   end

   // read-back
   always_comb begin
      case (idx)
         grmr_pkg::REG_COLUMNS: prdata = 32'(columns_ff);
         grmr_pkg::REG_ROWS:    prdata = 32'(rows_ff);
         grmr_pkg::REG_ORIG_X:  prdata = orig_x_ff;
         grmr_pkg::REG_ORIG_Y:  prdata = orig_y_ff;
         grmr_pkg::REG_PITCH:   prdata = 32'(pitch_ff);
         grmr_pkg::REG_MARKER:  prdata = marker_ff;
         grmr_pkg::REG_FILL:    prdata = fill_ff;
         default:               prdata = '0;
      endcase
   end

   // sizes saturate into range, zero pitch acts as one
   always_comb begin
      cfg = '0;
      if (int'(columns_ff) < 2)                     cfg.columns = grmr_pkg::DIM_W'(2);
      else if (int'(columns_ff) > grmr_pkg::MAX_COLUMNS)
         cfg.columns = grmr_pkg::DIM_W'(grmr_pkg::MAX_COLUMNS);
      else                                          cfg.columns = columns_ff;
      if (int'(rows_ff) < 2)                        cfg.rows = grmr_pkg::DIM_W'(2);
      else if (int'(rows_ff) > grmr_pkg::MAX_ROWS)
         cfg.rows = grmr_pkg::DIM_W'(grmr_pkg::MAX_ROWS);
      else                                          cfg.rows = rows_ff;
      cfg.origin_x = $signed(orig_x_ff);
      cfg.origin_y = $signed(orig_y_ff);
      cfg.pitch    = (pitch_ff == '0) ? grmr_pkg::PITCH_W'(1) : pitch_ff;
      cfg.marker   = $signed(marker_ff);
      cfg.fill     = $signed(fill_ff);
   end

endmodule
`default_nettype wire

/* hw/rtl/grmr_div.sv */
// Restoring divider, one quotient bit per cycle, shared by loads and queries.
`timescale 1ns / 1ps
`default_nettype none
module grmr_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  grmr_pkg::div_req_type      req,
   output grmr_pkg::div_rsp_type      rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [grmr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [grmr_pkg::PITCH_W-1:0] rem_ff, rem_in;
   logic [grmr_pkg::QUOT_W-1:0]  shr_ff, shr_in;
   logic [grmr_pkg::PITCH_W-1:0] den_ff, den_in;
   logic [grmr_pkg::PITCH_W:0]   trial;
   logic [grmr_pkg::PITCH_W:0]   diff;
   logic                         ge;

   // one trial subtraction
   assign trial = {rem_ff, shr_ff[grmr_pkg::QUOT_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shr_in  = shr_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = grmr_pkg::CNT_W'(grmr_pkg::QUOT_W);
         rem_in  = req.num[grmr_pkg::NUM_W-1:grmr_pkg::QUOT_W];
         shr_in  = req.num[grmr_pkg::QUOT_W-1:0];
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[grmr_pkg::PITCH_W-1:0] : trial[grmr_pkg::PITCH_W-1:0];
         shr_in = {shr_ff[grmr_pkg::QUOT_W-2:0], ge};
         cnt_in = cnt_ff - grmr_pkg::CNT_W'(1);
         if (cnt_ff == grmr_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      shr_ff <= shr_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = shr_ff;
   assign rsp.rem  = rem_ff;

endmodule
`default_nettype wire

/* hw/rtl/grmr_store.sv */
// Grid sample memory, single port, registered read.
`timescale 1ns / 1ps
`default_nettype none
module grmr_store (
   input  wire logic                        clock,
   input  wire logic                        we,
   input  wire logic [grmr_pkg::ADDR_W-1:0] addr,
   input  wire logic [grmr_pkg::DATA_W-1:0] wdata,
   output logic      [grmr_pkg::DATA_W-1:0] rdata
);

   logic [grmr_pkg::DATA_W-1:0] mem [grmr_pkg::STORE_DEPTH];
   logic [grmr_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* bench/grid_map_bilinear_resampler_unit_tb.sv */
// Testbench for the grid bilinear resampler: directed and random loads and queries checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module grid_map_bilinear_resampler_unit_tb;
   import grmr_pkg::*;

   // predictor of grid contents and interpolated values, with the queue of pending results
   class grid_scoreboard;
      bit [DIM_W-1:0]          cols_r, rows_r;
      bit signed [DATA_W-1:0]  ox, oy, marker, fill;
      bit [PITCH_W-1:0]        pitch;
      bit signed [DATA_W-1:0]  store [STORE_DEPTH];
      bit                      written [STORE_DEPTH];
      int unsigned             load_pos;
      bit signed [DATA_W-1:0]  pending_values [$];
      int                      errors;

      function new();
         cols_r = RST_COLUMNS; rows_r = RST_ROWS; pitch = RST_PITCH;
         marker = RST_MARKER; ox = 0; oy = 0; fill = 0; load_pos = 0; errors = 0;
         foreach (written[i]) written[i] = 0;
      endfunction

      function int eff_cols();
         return (cols_r < 2) ? 2 : (cols_r > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_r);
      endfunction

      function int eff_rows();
         return (rows_r < 2) ? 2 : (rows_r > MAX_ROWS) ? MAX_ROWS : int'(rows_r);
      endfunction

      function longint eff_pitch();
         return (pitch == 0) ? 1 : longint'(pitch);
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, bit [31:0] v);
         case (idx)
            REG_COLUMNS: cols_r = v[DIM_W-1:0];
            REG_ROWS:    rows_r = v[DIM_W-1:0];
            REG_ORIG_X:  ox = v;
            REG_ORIG_Y:  oy = v;
            REG_PITCH:   pitch = v[PITCH_W-1:0];
            REG_MARKER:  marker = v;
            REG_FILL:    fill = v;
            default: ;
         endcase
      endfunction

      // every entry a query could read has been loaded
      function bit grid_ready();
         for (int r = 0; r < eff_rows(); r++)
            for (int c = 0; c < eff_cols(); c++)
               if (!written[r*MAX_COLUMNS + c]) return 0;
         return 1;
      endfunction

      // lower cell index along one axis, weight in 0..65536
      function longint locate(longint q, longint org, int n, output longint w);
         longint p, first, last, d, k;
         p = eff_pitch();
         first = org + (p >>> 1);
         last = first + longint'(n - 1) * p;
         if (q < first) q = first;
         if (q > last) q = last;
         d = q - first;
         k = d / p;
         if (k > n - 2) k = n - 2;
         d -= k * p;
         w = (d * ONE_Q16) / p;
         return k;
      endfunction

      function longint weighted(longint v, longint w);
         return (v * w) >>> FRAC_W;
      endfunction

      function longint at(longint r, longint c);
         return longint'(store[(r * MAX_COLUMNS + c) % STORE_DEPTH]);
      endfunction

      function void note_item(bit cmd, bit signed [31:0] s, bit signed [31:0] x,
                              bit signed [31:0] y);
         int cols, rows, total, idx;
         longint wx, wy, i, j, v0, v1, v;
         cols = eff_cols(); rows = eff_rows(); total = cols * rows;
         if (!cmd) begin
            if (load_pos >= total) load_pos = 0;
            idx = (rows - 1 - int'(load_pos) / cols) * MAX_COLUMNS + int'(load_pos) % cols;
            store[idx] = (s == marker) ? fill : s;
            written[idx] = 1;
            load_pos++;
            if (load_pos >= total) load_pos = 0;
         end else begin
            i = locate(longint'(x), longint'(ox), cols, wx);
            j = locate(longint'(y), longint'(oy), rows, wy);
            v0 = weighted(at(j, i), ONE_Q16 - wx) + weighted(at(j, i + 1), wx);
            v1 = weighted(at(j + 1, i), ONE_Q16 - wx) + weighted(at(j + 1, i + 1), wx);
            v = weighted(v0, ONE_Q16 - wy) + weighted(v1, wy);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            pending_values.push_back(v[31:0]);
         end
      endfunction

      function void check_result(bit signed [31:0] got);
         bit signed [31:0] exp_v;
         if (pending_values.size() == 0) begin
            $display("%0t: unexpected result %0d", $time, got);
            errors++;
         end else begin
            exp_v = pending_values.pop_front();
            if (got !== exp_v) begin
               $display("%0t: interpolated_value expected %0d actual %0d", $time, exp_v, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock, reset, start, busy, req_command, rsp_valid;
   logic signed [31:0] req_sample_value, req_query_x, req_query_y, rsp_interpolated_value;
   logic psel, penable, pwrite, pready;
   logic [PADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;

   grid_scoreboard sb;
   int items_sent;

   grid_map_bilinear_resampler_unit DUT (.*);

   // clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // result monitor
   always @(posedge clock)
      if (!reset && rsp_valid === 1'b1) sb.check_result(rsp_interpolated_value);

   // run limit
   initial begin
      #20_000_000;
      $display("grid_map_bilinear_resampler_unit_tb: FAIL");
      $finish;
   end

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= PADDR_W'(idx) << 2; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.write_reg(idx, v);
   endtask

   // present one item and hold it until taken
   task automatic send_item(bit cmd, bit signed [31:0] s, bit signed [31:0] x,
                            bit signed [31:0] y);
      start <= 1; req_command <= cmd;
      req_sample_value <= s; req_query_x <= x; req_query_y <= y;
      do @(posedge clock); while (busy);
      sb.note_item(cmd, s, x, y);
      items_sent++;
   endtask

   // mostly short gaps, a few long ones
   task automatic item_gap();
      int g, n;
      n = $urandom_range(0, 99);
      g = (n < 40) ? 0 : (n < 85) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      if (g > 0) begin
         start <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 0;
      while (sb.pending_values.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic bit signed [31:0] pick_sample();
      int n;
      n = $urandom_range(0, 99);
      if (n < 10) return sb.marker;
      if (n < 15) return 32'sh7FFF_FFFF;
      if (n < 20) return 32'sh8000_0000;
      if (n < 45) return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      return $urandom;
   endfunction

   // coordinate near or across the span of cell centres on one axis
   function automatic bit signed [31:0] pick_coord(bit signed [31:0] org, int n);
      longint p, first, c;
      int sel;
      p = sb.eff_pitch();
      first = longint'(org) + (p >>> 1);
      sel = $urandom_range(0, 99);
      if (sel < 15) return $urandom;
      if (sel < 25) c = first + longint'($urandom_range(0, n - 1)) * p;
      else c = first - p + ((longint'(n + 1) * p * $urandom_range(0, 65535)) >>> 16);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
      return c[31:0];
   endfunction

   function automatic logic [31:0] pick_size(bit keep_small);
      int n;
      n = $urandom_range(0, 99);
      if (n < 5) return {25'($urandom_range(0, 32'h1FF_FFFF)), 7'd0};
      if (n < 10) return 1;
      if (n < 20) return 2;
      if (!keep_small && n < 27) return 127;
      if (!keep_small && n < 34) return 64;
      return $urandom_range(3, 8);
   endfunction

   function automatic logic [31:0] pick_pitch();
      int n;
      n = $urandom_range(0, 99);
      if (n < 5) return 0;
      if (n < 10) return 1;
      if (n < 15) return 32'h7FFF_FFFF;
      if (n < 30) return 32'h8001_0000;
      if (n < 45) return $urandom;
      return $urandom_range(1, 32'h0010_0000);
   endfunction

   function automatic logic [31:0] pick_origin();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
   endfunction

   initial begin
      bit signed [31:0] x0, y0;
      logic [31:0] cv;
      int n_items;
      sb = new();
      items_sent = 0;
      reset = 1; start = 0; req_command = 0;
      req_sample_value = 0; req_query_x = 0; req_query_y = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: 3 x 2 unit grid with a fill value and extreme samples
      csr_write(REG_COLUMNS, 3);
      csr_write(REG_ROWS, 2);
      csr_write(REG_FILL, 32'h1234_5678);
      send_item(0, 32'sh7FFF_FFFF, 0, 0);
      send_item(0, RST_MARKER, 0, 0);
      send_item(0, 32'sh8000_0000, 0, 0);
      send_item(0, RST_MARKER + 1, 0, 0);
      send_item(0, 32'sh0001_0000, 0, 0);
      item_gap();
      send_item(0, -32'sh0003_8000, 0, 0);
      send_item(1, 0, 32'sh8000_0000, 32'sh8000_0000);
      send_item(1, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_item(1, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_item(1, 0, 32'sh0000_8000, 32'sh0000_8000);
      send_item(1, 0, 32'sh0002_8000, 32'sh0001_8000);
      send_item(1, 0, 32'sh0001_0000, 32'sh0001_0000);
      send_item(1, 0, 32'sh0001_C000, 32'sh0000_C001);
      send_item(1, 0, 32'sh0002_7FFF, 32'sh0001_7FFF);
      send_item(1, 0, 32'sh0001_8000, 32'sh0000_8000);
      item_gap();
      send_item(1, 0, 32'sh0000_0001, 32'sh0002_0000);
      wait_idle();

      // random phases, each with its own register setting
      while (items_sent < 1650) begin
         cv = pick_size(0);
         csr_write(REG_COLUMNS, cv);
         csr_write(REG_ROWS, pick_size(sb.eff_cols() > 8));
         if ($urandom_range(0, 1)) csr_write(REG_ORIG_X, pick_origin());
         if ($urandom_range(0, 1)) csr_write(REG_ORIG_Y, pick_origin());
         if ($urandom_range(0, 2) != 0) csr_write(REG_PITCH, pick_pitch());
         if ($urandom_range(0, 3) == 0) csr_write(REG_MARKER, $urandom);
         if ($urandom_range(0, 3) == 0) csr_write(REG_FILL, $urandom);

         // fill the grid before any query may read it
         if (!sb.grid_ready())
            repeat (sb.eff_cols() * sb.eff_rows()) begin
               send_item(0, pick_sample(), $urandom, $urandom);
               item_gap();
            end

         n_items = $urandom_range(20, 80);
         repeat (n_items) begin
            if ($urandom_range(0, 99) < 70) begin
               x0 = pick_coord(sb.ox, sb.eff_cols());
               y0 = pick_coord(sb.oy, sb.eff_rows());
               send_item(1, $urandom, x0, y0);
            end else
               send_item(0, pick_sample(), $urandom, $urandom);
            item_gap();
         end
         wait_idle();
      end

      // drain, then close the run
      n_items = 0;
      while (sb.pending_values.size() != 0 && n_items < 1000) begin
         @(posedge clock);
         n_items++;
      end
      repeat (70) @(posedge clock);
      if (sb.errors == 0 && sb.pending_values.size() == 0)
         $display("grid_map_bilinear_resampler_unit_tb: PASS");
      else
         $display("grid_map_bilinear_resampler_unit_tb: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
